// ----- hw/rtl/nth_pkg.sv -----
// ----------------------------------------------------------------------------
// nth_pkg: shared types and constants for the nearest target heading block
// Beat structs for both channels, the offset carried between front and back,
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package nth_pkg;

  typedef struct packed {
    logic signed [15:0] self_x;
    logic signed [15:0] self_y;
    logic signed [15:0] neighbor_x;
    logic signed [15:0] neighbor_y;
    logic               last_neighbor;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic               coincident;
  } out_item_t;

  // Offset of the nearest neighbour, Q13.4.
  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } offset_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  // CORDIC vector width (offset shifted left by 8, plus gain headroom) and
  // angle accumulator width (radians, 20 fraction bits).
  localparam int unsigned XW = 28;
  localparam int unsigned ZW = 25;

  localparam logic signed [ZW-1:0] AnglePi      = 25'sd3294199;
  localparam logic signed [15:0]   HeadingLimit = 16'sd25736;

  // atan(2^-i) at 20 fraction bits, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      5'd0:    val = 25'sd823550;
      5'd1:    val = 25'sd486170;
      5'd2:    val = 25'sd256879;
      5'd3:    val = 25'sd130396;
      5'd4:    val = 25'sd65451;
      5'd5:    val = 25'sd32757;
      5'd6:    val = 25'sd16383;
      5'd7:    val = 25'sd8192;
      5'd8:    val = 25'sd4096;
      5'd9:    val = 25'sd2048;
      5'd10:   val = 25'sd1024;
      5'd11:   val = 25'sd512;
      5'd12:   val = 25'sd256;
      5'd13:   val = 25'sd128;
      5'd14:   val = 25'sd64;
      5'd15:   val = 25'sd32;
      5'd16:   val = 25'sd16;
      5'd17:   val = 25'sd8;
      5'd18:   val = 25'sd4;
      5'd19:   val = 25'sd2;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- hw/rtl/nth_front.sv -----
// ----------------------------------------------------------------------------
// nth_front: nearest neighbour search
// Three-stage pipeline: offset, squares, then compare against the best so
// far. The chosen offset of each run is pushed into the queue on its last beat.
// ----------------------------------------------------------------------------
module nth_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nth_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output nth_pkg::offset_t  push_data_o
);

  logic advance;

  logic signed [16:0] dx_in, dy_in;

  logic               s1_valid_q, s1_valid_d;
  logic signed [16:0] s1_dx_q, s1_dy_q;
  logic               s1_last_q;

  logic [16:0]        ax, ay;
  logic [31:0]        sqx, sqy;
  logic               s2_valid_q, s2_valid_d;
  logic [31:0]        s2_sqx_q, s2_sqy_q;
  logic signed [16:0] s2_dx_q, s2_dy_q;
  logic               s2_last_q;

  logic [32:0]        sum_sq;
  logic               take;
  logic               holding_q, holding_d;
  logic [32:0]        best_dist_q, best_dist_d;
  nth_pkg::offset_t   best_q, best_d;

  // The whole pipeline holds while the queue is full.
  assign advance    = !q_full_i;
  assign in_stall_o = q_full_i;

  assign dx_in = {in_data_i.neighbor_x[15], in_data_i.neighbor_x}
               - {in_data_i.self_x[15], in_data_i.self_x};
  assign dy_in = {in_data_i.neighbor_y[15], in_data_i.neighbor_y}
               - {in_data_i.self_y[15], in_data_i.self_y};

  assign s1_valid_d = in_valid_i;

  assign ax  = s1_dx_q[16] ? 17'(-s1_dx_q) : 17'(s1_dx_q);
  assign ay  = s1_dy_q[16] ? 17'(-s1_dy_q) : 17'(s1_dy_q);
  assign sqx = ax[15:0] * ax[15:0];
  assign sqy = ay[15:0] * ay[15:0];
  assign s2_valid_d = s1_valid_q;

  assign sum_sq = {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};
  // Strict compare keeps the earlier neighbour on a tie.
  assign take = !holding_q || (sum_sq < best_dist_q);

  always_comb begin
    best_dist_d = best_dist_q;
    best_d      = best_q;
    holding_d   = holding_q;
    if (s2_valid_q) begin
      if (take) begin
        best_dist_d = sum_sq;
        best_d.dx   = s2_dx_q;
        best_d.dy   = s2_dy_q;
      end
      holding_d = !s2_last_q;
    end
  end

  assign push_o      = advance && s2_valid_q && s2_last_q;
  assign push_data_o = best_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      holding_q  <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      holding_q  <= holding_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_dx_q     <= dx_in;
      s1_dy_q     <= dy_in;
      s1_last_q   <= in_data_i.last_neighbor;
      s2_sqx_q    <= sqx;
      s2_sqy_q    <= sqy;
      s2_dx_q     <= s1_dx_q;
      s2_dy_q     <= s1_dy_q;
      s2_last_q   <= s1_last_q;
      best_dist_q <= best_dist_d;
      best_q      <= best_d;
    end
  end

endmodule

// ----- hw/rtl/nth_queue.sv -----
// ----------------------------------------------------------------------------
// nth_queue: offset queue between search and heading unit
// Small circular buffer that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module nth_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nth_pkg::offset_t push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output nth_pkg::offset_t pop_data_o
);

  nth_pkg::offset_t                  mem_q [nth_pkg::QueueDepth];
  logic [nth_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [nth_pkg::QueueCntW-1:0]     count_q, count_d;
  logic                              do_push, do_pop;

  assign full_o      = (count_q == nth_pkg::QueueCntW'(nth_pkg::QueueDepth));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && pop_valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/nth_back.sv -----
// ----------------------------------------------------------------------------
// nth_back: iterative CORDIC atan2 heading unit
// One rotation step per cycle, then rounding, clamping and an output register.
// ----------------------------------------------------------------------------
module nth_back #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  nth_pkg::offset_t   q_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nth_pkg::out_item_t out_data_o
);

  localparam int unsigned CntW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int unsigned XW   = nth_pkg::XW;
  localparam int unsigned ZW   = nth_pkg::ZW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic                 coin_q, coin_d;
  logic                 out_valid_q, out_valid_d;
  nth_pkg::out_item_t   out_data_q, out_data_d;

  logic signed [XW-1:0] x0, y0, xs, ys;
  logic signed [ZW-1:0] ang;
  logic signed [ZW:0]   zr_sum, zr;
  logic signed [15:0]   head;
  logic                 slot_free, load_out;

  assign x0 = {{(XW-25){q_data_i.dx[16]}}, q_data_i.dx, 8'b0};
  assign y0 = {{(XW-25){q_data_i.dy[16]}}, q_data_i.dy, 8'b0};

  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign ang = nth_pkg::atan_entry(5'(cnt_q));

  // Round half up to Q3.13, then clamp.
  assign zr_sum = {z_q[ZW-1], z_q} + (ZW+1)'(64);
  assign zr     = zr_sum >>> 7;
  always_comb begin
    if (zr > (ZW+1)'(nth_pkg::HeadingLimit)) begin
      head = nth_pkg::HeadingLimit;
    end else if (zr < -(ZW+1)'(nth_pkg::HeadingLimit)) begin
      head = -nth_pkg::HeadingLimit;
    end else begin
      head = 16'(zr);
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == StDone) && slot_free;
  assign q_pop_o   = (state_q == StIdle) && q_valid_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    coin_d      = coin_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          cnt_d  = '0;
          coin_d = (q_data_i.dx == '0) && (q_data_i.dy == '0);
          if (q_data_i.dx[16]) begin
            x_d = -x0;
            y_d = -y0;
            z_d = q_data_i.dy[16] ? -nth_pkg::AnglePi : nth_pkg::AnglePi;
          end else begin
            x_d = x0;
            y_d = y0;
            z_d = '0;
          end
          state_d = StRun;
        end
      end
      StRun: begin
        if (!y_q[XW-1]) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + ang;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - ang;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(CORDIC_STEPS - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (slot_free) begin
          out_data_d.heading    = coin_q ? '0 : head;
          out_data_d.coincident = coin_q;
          out_valid_d           = 1'b1;
          state_d               = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    coin_q <= coin_d;
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hw/rtl/nearest_target_heading.sv -----
// ----------------------------------------------------------------------------
// nearest_target_heading: heading toward the nearest neighbour of each run
// Finds the nearest neighbour by squared distance and reports the atan2
// heading toward it as a Q3.13 angle in radians.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents                       Handshake
//   in       input      own and neighbour position, last    in_valid_i / in_stall_o
//   out      output     heading, coincident flag            out_valid_o / out_stall_i
//
// The search front takes one beat every cycle while the queue has room; its
// three-stage pipeline (offset, squares, compare) places the chosen offset
// of a run in a four-entry queue once the run's last beat reaches compare.
// The heading unit is an iterative CORDIC: it loads an offset, runs CORDIC_STEPS
// rotation steps, then rounds and clamps, and only then pops the next offset.
// Reset is asynchronous and active low; it empties the pipeline and queue
// and forgets any partial run. No clearing pass is needed.
// in_stall_o is high only while the queue is full, which happens when runs
// end faster than the heading unit produces results or out_stall_i holds the
// output register; the front then freezes as a whole.
//
module nearest_target_heading #(
  parameter int unsigned CORDIC_STEPS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nth_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nth_pkg::out_item_t out_data_o
);

  // Front to queue.
  logic             push;
  nth_pkg::offset_t push_data;
  logic             q_full;

  // Queue to back.
  logic             q_valid;
  logic             q_pop;
  nth_pkg::offset_t q_data;

  // The front compares squared distances, so no root is taken; on a tie the
  // earlier neighbour stays.
  nth_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // The queue decouples the search, which takes one beat per cycle while the queue
  // has room, from the slower heading computation.
  nth_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  // A negative x offset is folded into the right half-plane with a start
  // angle of plus or minus pi, so the full atan2 range is covered. A
  // neighbour on the own position gives heading zero with the flag set.
  nth_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/nth_checker.sv -----
// ----------------------------------------------------------------------------
// nth_checker: port-level checks for nearest_target_heading
// Watches the output channel of the top level; attached with a bind.
// ----------------------------------------------------------------------------
module nth_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input nth_pkg::out_item_t out_data_i
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_data_i))
    else $error("output beat changed while stalled");

  a_coincident_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.coincident |-> out_data_i.heading == 16'sd0)
    else $error("coincident beat with non-zero heading");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.heading <= nth_pkg::HeadingLimit)
                 && (out_data_i.heading >= -nth_pkg::HeadingLimit))
    else $error("heading outside clamp range");

endmodule

bind nearest_target_heading nth_checker u_nth_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
